/* rtl/core/stsp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stsp_pkg: shared types and constants of the sub-page table slot pool
// Word layouts of both channels, the search token that walks the cell chain,
// the command group from the controller to the cells and the status codes.
// ----------------------------------------------------------------------------
package stsp_pkg;

    // defaults for the top level parameters
    localparam int unsigned POOL_PAGES_DEF     = 16;
    localparam int unsigned SLOTS_PER_PAGE_DEF = 4;

    // fixed field widths and address geometry
    localparam int unsigned FRAME_W    = 20;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned SLOT_SHIFT = 10;
    localparam int unsigned SLOT_BYTES = 1024;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_MEM  = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;
    localparam logic [1:0] STATUS_IGNORED = 2'd3;

    typedef struct packed {
        logic                operation;
        logic [ADDR_W-1:0]   free_address;
        logic [FRAME_W-1:0]  spare_frame;
    } in_word_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [ADDR_W-1:0]   slot_address;
        logic                spare_taken;
        logic                frame_released;
        logic [FRAME_W-1:0]  released_frame;
    } out_word_t;

    // search token handed from cell to cell, newest entry first
    typedef struct packed {
        logic                active;
        logic                found;
        logic                dropped;
        logic [ADDR_W-1:0]   slot_address;
        logic                released;
        logic [FRAME_W-1:0]  released_frame;
    } token_t;

    // commands broadcast to every cell
    typedef struct packed {
        logic                insert;
        logic                compact;
    } cmd_t;

    // byte address of the first slot of a page
    function automatic logic [ADDR_W-1:0] page_base(input logic [FRAME_W-1:0] frame);
        page_base = {frame, {PAGE_SHIFT{1'b0}}};
    endfunction

endpackage
`default_nettype wire

/* rtl/core/subpage_table_slot_pool.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// subpage_table_slot_pool: allocator of 1 KB table slots packed into pages
// Top level with the request controller and the chain of page entry cells.
// ----------------------------------------------------------------------------
// The pool keeps up to POOL_PAGES page entries in a chain of cells ordered
// from newest (cell 0) to oldest. Each request word is held while a search
// token walks the chain, one cell per clock; the result word is registered once
// the token has left the last cell and the output register is free, and the next
// word is accepted in the cycle after the result is produced. A free of address
// zero skips the search. New pages enter at the head and shift the chain by one,
// emptied pages leave and the older entries move up by one, both at the edge
// that registers the result word. A finished result sits in the output register,
// so a new request word can be taken while it waits.
// ----------------------------------------------------------------------------
module subpage_table_slot_pool #(
    parameter int unsigned POOL_PAGES     = stsp_pkg::POOL_PAGES_DEF,
    parameter int unsigned SLOTS_PER_PAGE = stsp_pkg::SLOTS_PER_PAGE_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  stsp_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output stsp_pkg::out_word_t  m_data
);
    import stsp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t    state_reg;
    in_word_t  req_reg;
    logic      start_reg;
    token_t    res_reg;
    logic      m_valid_reg;
    out_word_t m_data_reg;

    token_t                    tok_chain [POOL_PAGES+1];
    logic                      cell_live [POOL_PAGES];
    logic [FRAME_W-1:0]        cell_frame [POOL_PAGES];
    logic [SLOTS_PER_PAGE-1:0] cell_mask [POOL_PAGES];

    cmd_t      cmd;
    out_word_t res_word;
    logic      emit;
    logic      insert_hit;
    logic      compact_hit;

    // token enters the newest cell in the same cycle the request is first held
    always_comb begin
        tok_chain[0]        = '0;
        tok_chain[0].active = start_reg;
    end

    // chain of entry cells
    for (genvar i = 0; i < POOL_PAGES; i++) begin : g_cell
        logic                      p_live, n_live;
        logic [FRAME_W-1:0]        p_frame, n_frame;
        logic [SLOTS_PER_PAGE-1:0] p_mask, n_mask;

        if (i == 0) begin : g_head
            assign p_live  = 1'b1;
            assign p_frame = req_reg.spare_frame;
            assign p_mask  = SLOTS_PER_PAGE'(1);
        end else begin : g_body
            assign p_live  = cell_live[i-1];
            assign p_frame = cell_frame[i-1];
            assign p_mask  = cell_mask[i-1];
        end

        if (i == POOL_PAGES - 1) begin : g_tail
            assign n_live  = 1'b0;
            assign n_frame = '0;
            assign n_mask  = '0;
        end else begin : g_link
            assign n_live  = cell_live[i+1];
            assign n_frame = cell_frame[i+1];
            assign n_mask  = cell_mask[i+1];
        end

        stsp_cell #(
            .SLOTS_PER_PAGE(SLOTS_PER_PAGE)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .req        (req_reg),
            .cmd        (cmd),
            .tok_in     (tok_chain[i]),
            .tok_out    (tok_chain[i+1]),
            .prev_live  (p_live),
            .prev_frame (p_frame),
            .prev_mask  (p_mask),
            .next_live  (n_live),
            .next_frame (n_frame),
            .next_mask  (n_mask),
            .live       (cell_live[i]),
            .frame      (cell_frame[i]),
            .mask       (cell_mask[i])
        );
    end

    assign emit = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    // result word and chain command from the search outcome
    always_comb begin
        res_word    = '0;
        insert_hit  = 1'b0;
        compact_hit = 1'b0;
        if (req_reg.operation == OP_ALLOC) begin
            if (res_reg.found) begin
                res_word.status       = STATUS_OK;
                res_word.slot_address = res_reg.slot_address;
            end else if (req_reg.spare_frame == '0) begin
                res_word.status = STATUS_NO_MEM;
            end else if (cell_live[POOL_PAGES-1]) begin
                res_word.status = STATUS_FULL;
            end else begin
                res_word.status       = STATUS_OK;
                res_word.slot_address = page_base(req_reg.spare_frame);
                res_word.spare_taken  = 1'b1;
                insert_hit            = 1'b1;
            end
        end else begin
            if (req_reg.free_address == '0 || !res_reg.found) begin
                res_word.status = STATUS_IGNORED;
            end else begin
                res_word.status         = STATUS_OK;
                res_word.frame_released = res_reg.released;
                res_word.released_frame = res_reg.released_frame;
                compact_hit             = res_reg.dropped;
            end
        end
        cmd.insert  = emit && insert_hit;
        cmd.compact = emit && compact_hit;
    end

    // request controller and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // token launch in the cycle after a searching word is taken
            start_reg <= (state_reg == ST_IDLE) && s_valid &&
                         !(s_data.operation == OP_FREE && s_data.free_address == '0);
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        req_reg <= s_data;
                        res_reg <= '0;
                        if (s_data.operation == OP_FREE && s_data.free_address == '0) begin
                            state_reg <= ST_FINISH;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (tok_chain[POOL_PAGES].active) begin
                        res_reg   <= tok_chain[POOL_PAGES];
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (emit) begin
                        m_data_reg <= res_word;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // one word in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in flight");

    // token leaves the chain only during a search
    assert property (@(posedge aclk) disable iff (!aresetn)
        tok_chain[POOL_PAGES].active |-> (state_reg == ST_SCAN))
        else $error("search token left the chain outside a search");

    // insert and compaction never together
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.insert && cmd.compact))
        else $error("insert and compaction issued together");

    // the oldest entry, when live, always has a slot in use and a nonzero frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        cell_live[POOL_PAGES-1] |-> (cell_mask[POOL_PAGES-1] != '0))
        else $error("live entry with empty used mask");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cell_live[POOL_PAGES-1] |-> (cell_frame[POOL_PAGES-1] != '0))
        else $error("live entry with frame zero");

    // a taken spare frame always comes with a good status
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.spare_taken) |-> (m_data_reg.status == STATUS_OK))
        else $error("spare frame taken without ok status");

endmodule
`default_nettype wire

/* rtl/core/stsp_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stsp_cell: one page entry of the slot pool chain
// Holds a frame number, a used mask and a live flag. The search token passes
// through one cell per cycle; the first matching cell claims or frees a slot.
// On insert the cell takes its younger neighbour's entry, on compaction the
// cells from the dropped entry onwards take their older neighbour's entry.
// ----------------------------------------------------------------------------
module stsp_cell #(
    parameter int unsigned SLOTS_PER_PAGE = stsp_pkg::SLOTS_PER_PAGE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  stsp_pkg::in_word_t            req,
    input  stsp_pkg::cmd_t                cmd,
    input  stsp_pkg::token_t              tok_in,
    output stsp_pkg::token_t              tok_out,
    input  logic                          prev_live,
    input  logic [stsp_pkg::FRAME_W-1:0]  prev_frame,
    input  logic [SLOTS_PER_PAGE-1:0]     prev_mask,
    input  logic                          next_live,
    input  logic [stsp_pkg::FRAME_W-1:0]  next_frame,
    input  logic [SLOTS_PER_PAGE-1:0]     next_mask,
    output logic                          live,
    output logic [stsp_pkg::FRAME_W-1:0]  frame,
    output logic [SLOTS_PER_PAGE-1:0]     mask
);
    import stsp_pkg::*;

    localparam int unsigned SLOT_W = $clog2(SLOTS_PER_PAGE);
    localparam logic [ADDR_W-1:0] PAGE_SPAN = ADDR_W'(SLOTS_PER_PAGE * SLOT_BYTES);

    logic                      live_reg, live_next;
    logic [FRAME_W-1:0]        frame_reg, frame_next;
    logic [SLOTS_PER_PAGE-1:0] mask_reg, mask_next;
    logic                      shift_reg, shift_next;
    token_t                    tok_reg, tok_next;

    logic [ADDR_W-1:0]         base;
    logic [ADDR_W-1:0]         offset;
    logic                      in_page;
    logic [SLOT_W-1:0]         free_slot;
    logic [SLOT_W-1:0]         first_free;
    logic                      has_free;
    logic [SLOTS_PER_PAGE-1:0] set_bit;
    logic [SLOTS_PER_PAGE-1:0] clr_bit;
    logic [SLOTS_PER_PAGE-1:0] mask_freed;
    logic                      claim_alloc;
    logic                      claim_free;

    // address match and slot selection
    always_comb begin
        base      = page_base(frame_reg);
        offset    = req.free_address - base;
        in_page   = offset < PAGE_SPAN;
        free_slot = offset[SLOT_SHIFT +: SLOT_W];
        has_free  = ~&mask_reg;
        first_free = '0;
        for (int i = SLOTS_PER_PAGE - 1; i >= 0; i--) begin
            if (!mask_reg[i]) begin
                first_free = SLOT_W'(i);
            end
        end
        for (int i = 0; i < SLOTS_PER_PAGE; i++) begin
            set_bit[i] = (first_free == SLOT_W'(i));
            clr_bit[i] = (free_slot == SLOT_W'(i));
        end
        mask_freed = mask_reg & ~clr_bit;
    end

    assign claim_alloc = tok_in.active && !tok_in.found && live_reg &&
                         (req.operation == OP_ALLOC) && has_free;
    assign claim_free  = tok_in.active && !tok_in.found && live_reg &&
                         (req.operation == OP_FREE) && in_page;

    // entry update and token hand-on
    always_comb begin
        live_next  = live_reg;
        frame_next = frame_reg;
        mask_next  = mask_reg;
        shift_next = shift_reg;
        tok_next   = tok_in;

        if (claim_alloc) begin
            mask_next             = mask_reg | set_bit;
            tok_next.found        = 1'b1;
            tok_next.slot_address = base + (ADDR_W'(first_free) << SLOT_SHIFT);
        end

        if (claim_free) begin
            mask_next      = mask_freed;
            tok_next.found = 1'b1;
            if (mask_freed == '0) begin
                live_next               = 1'b0;
                shift_next              = 1'b1;
                tok_next.dropped        = 1'b1;
                tok_next.released       = 1'b1;
                tok_next.released_frame = frame_reg;
            end
        end

        // entries older than a dropped one close the gap later
        if (tok_in.active && tok_in.dropped) begin
            shift_next = 1'b1;
        end

        if (cmd.insert) begin
            live_next  = prev_live;
            frame_next = prev_frame;
            mask_next  = prev_mask;
        end

        if (cmd.compact) begin
            shift_next = 1'b0;
            if (shift_reg) begin
                live_next  = next_live;
                frame_next = next_frame;
                mask_next  = next_mask;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg  <= 1'b0;
            mask_reg  <= '0;
            shift_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            live_reg  <= live_next;
            mask_reg  <= mask_next;
            shift_reg <= shift_next;
            tok_reg   <= tok_next;
        end
    end

    // frame number, only read while live
    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
    end

    assign tok_out = tok_reg;
    assign live    = live_reg;
    assign frame   = frame_reg;
    assign mask    = mask_reg;

endmodule
`default_nettype wire

/* test/slot_pool_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_pool_checker: result predictor and scoreboard of the slot pool
// Watches both channels of the pool. Keeps its own copy of the page table and
// works out the result word of every accepted request word. Each accepted
// result word is then compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module slot_pool_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  stsp_pkg::in_word_t   s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  stsp_pkg::out_word_t  m_data,
    output int                   mismatch_count,
    output int                   results_pending
);
    import stsp_pkg::*;

    localparam int PAGES = POOL_PAGES_DEF;
    localparam int SLOTS = SLOTS_PER_PAGE_DEF;
    localparam logic [SLOTS-1:0] ALL_USED = '1;

    // shadow page table
    logic [FRAME_W-1:0] pg_frame [PAGES];
    logic [SLOTS-1:0]   pg_used  [PAGES];
    logic               pg_live  [PAGES];
    int                 pg_rank  [PAGES];

    out_word_t expected_words [$];
    int        fail_tally = 0;
    int        pending_q  = 0;

    assign mismatch_count  = fail_tally;
    assign results_pending = pending_q;

    // result of one request word, updating the shadow table
    function automatic out_word_t predict_slot_result(input in_word_t w);
        out_word_t          r;
        int                 best;
        int                 empty;
        int                 s;
        int                 old_rank;
        logic [ADDR_W-1:0]  off;
        r     = '0;
        best  = -1;
        empty = -1;
        s     = -1;
        r.status = STATUS_OK;
        if (w.operation == OP_ALLOC) begin
            // newest entry with a free slot
            for (int i = 0; i < PAGES; i++) begin
                if (pg_live[i] && pg_used[i] != ALL_USED &&
                    (best < 0 || pg_rank[i] < pg_rank[best])) begin
                    best = i;
                end
            end
            if (best >= 0) begin
                for (int k = SLOTS - 1; k >= 0; k--) begin
                    if (!pg_used[best][k]) begin
                        s = k;
                    end
                end
                pg_used[best][s] = 1'b1;
                r.slot_address = {pg_frame[best], 12'h000} + ADDR_W'(s * SLOT_BYTES);
            end else if (w.spare_frame == '0) begin
                r.status = STATUS_NO_MEM;
            end else begin
                for (int i = PAGES - 1; i >= 0; i--) begin
                    if (!pg_live[i]) begin
                        empty = i;
                    end
                end
                if (empty < 0) begin
                    r.status = STATUS_FULL;
                end else begin
                    // spare frame becomes the newest entry
                    for (int i = 0; i < PAGES; i++) begin
                        if (pg_live[i]) begin
                            pg_rank[i]++;
                        end
                    end
                    pg_live[empty]  = 1'b1;
                    pg_frame[empty] = w.spare_frame;
                    pg_used[empty]  = '0;
                    pg_used[empty][0] = 1'b1;
                    pg_rank[empty]  = 0;
                    r.slot_address  = {w.spare_frame, 12'h000};
                    r.spare_taken   = 1'b1;
                end
            end
        end else begin
            if (w.free_address == '0) begin
                r.status = STATUS_IGNORED;
            end else begin
                // newest live page that holds the address
                for (int i = 0; i < PAGES; i++) begin
                    off = w.free_address - {pg_frame[i], 12'h000};
                    if (pg_live[i] && off < ADDR_W'(SLOTS * SLOT_BYTES) &&
                        (best < 0 || pg_rank[i] < pg_rank[best])) begin
                        best = i;
                    end
                end
                if (best < 0) begin
                    r.status = STATUS_IGNORED;
                end else begin
                    off = w.free_address - {pg_frame[best], 12'h000};
                    s = int'(off >> SLOT_SHIFT);
                    pg_used[best][s] = 1'b0;
                    if (pg_used[best] == '0) begin
                        // empty page goes back, older entries move up
                        old_rank = pg_rank[best];
                        r.frame_released = 1'b1;
                        r.released_frame = pg_frame[best];
                        pg_live[best] = 1'b0;
                        pg_rank[best] = 0;
                        for (int i = 0; i < PAGES; i++) begin
                            if (pg_live[i] && pg_rank[i] > old_rank) begin
                                pg_rank[i]--;
                            end
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    // scoreboard: result words first, so a word taken at this edge never matches
    always @(posedge aclk) begin : watch
        out_word_t want;
        if (!aresetn) begin
            expected_words.delete();
            for (int i = 0; i < PAGES; i++) begin
                pg_frame[i] = '0;
                pg_used[i]  = '0;
                pg_live[i]  = 1'b0;
                pg_rank[i]  = 0;
            end
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with none expected: %h", $time, m_data);
                    fail_tally++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_data.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, m_data.status);
                        fail_tally++;
                    end
                    if (m_data.slot_address !== want.slot_address) begin
                        $display("%0t: slot_address expected %h, got %h",
                                 $time, want.slot_address, m_data.slot_address);
                        fail_tally++;
                    end
                    if (m_data.spare_taken !== want.spare_taken) begin
                        $display("%0t: spare_taken expected %b, got %b",
                                 $time, want.spare_taken, m_data.spare_taken);
                        fail_tally++;
                    end
                    if (m_data.frame_released !== want.frame_released) begin
                        $display("%0t: frame_released expected %b, got %b",
                                 $time, want.frame_released, m_data.frame_released);
                        fail_tally++;
                    end
                    if (m_data.released_frame !== want.released_frame) begin
                        $display("%0t: released_frame expected %h, got %h",
                                 $time, want.released_frame, m_data.released_frame);
                        fail_tally++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_words.push_back(predict_slot_result(s_data));
            end
        end
        pending_q <= expected_words.size();
    end

endmodule

/* test/subpage_table_slot_pool_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// subpage_table_slot_pool_tb: test bench of the sub-page table slot pool
// Drives directed request words over the slot pool corner cases, then bursts
// of random allocations and frees over a small set of page frames, so pages
// fill, overflow the table and empty again. Both channels stall at random.
// ----------------------------------------------------------------------------
module subpage_table_slot_pool_tb;
    import stsp_pkg::*;

    localparam int RANDOM_WORDS = 800;
    localparam int FRAME_SET    = 20;
    localparam int DRAIN_CYCLES = 2 * (POOL_PAGES_DEF + 3) + 8;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    int mismatch_count;
    int results_pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    logic [FRAME_W-1:0] frame_set [FRAME_SET];

    subpage_table_slot_pool dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    slot_pool_checker scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // one request word, with a random gap in front
    task automatic send_word(input logic op, input logic [ADDR_W-1:0] addr,
                             input logic [FRAME_W-1:0] spare);
        in_word_t w;
        w.operation    = op;
        w.free_address = addr;
        w.spare_frame  = spare;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold the sender until every result word is back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
    endtask

    // random word, mostly aimed at slots of the frame set
    task automatic send_random_word(input int alloc_pct);
        logic               op;
        logic [ADDR_W-1:0]  addr;
        logic [FRAME_W-1:0] spare;
        int unsigned        pick;
        op    = ($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_FREE;
        spare = ($urandom_range(99) < 8) ? '0 : frame_set[$urandom_range(FRAME_SET - 1)];
        pick  = $urandom_range(99);
        if (pick < 4) begin
            addr = '0;
        end else if (pick < 14) begin
            addr = $urandom;
        end else begin
            addr = {frame_set[$urandom_range(FRAME_SET - 1)], 2'($urandom_range(3)),
                    10'($urandom)};
        end
        send_word(op, addr, spare);
    endtask

    // bursts of changing alloc/free mix
    task automatic run_phase(input int tx_pct, input int rx_pct, input int count);
        int sent;
        int burst;
        int alloc_pct;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(3))
                0: alloc_pct = 97;
                1: alloc_pct = 80;
                2: alloc_pct = 50;
                default: alloc_pct = 20;
            endcase
            burst = $urandom_range(90, 10);
            for (int i = 0; i < burst && sent < count; i++) begin
                send_random_word(alloc_pct);
                sent++;
            end
        end
    endtask

    initial begin
        frame_set[0] = 20'hFFFFF;
        frame_set[1] = 20'h00001;
        frame_set[2] = 20'h80000;
        for (int i = 3; i < FRAME_SET; i++) begin
            frame_set[i] = 20'($urandom_range(20'hFFFFF, 1));
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 26;
        rx_idle_pct = 58;

        // empty pool: no spare, zero free, free outside any page
        send_word(OP_ALLOC, 32'h0000_0000, 20'h00000);
        send_word(OP_FREE,  32'h0000_0000, 20'h12345);
        send_word(OP_FREE,  32'h1234_5678, 20'h00000);
        // top frame filled slot by slot, free address on an alloc is ignored
        send_word(OP_ALLOC, 32'hFFFF_FFFF, 20'hFFFFF);
        send_word(OP_ALLOC, 32'h0000_0000, 20'h00000);
        send_word(OP_ALLOC, 32'h0000_0000, 20'h00000);
        send_word(OP_ALLOC, 32'h0000_0000, 20'h00000);
        // page full and no spare, then a fresh page at frame one
        send_word(OP_ALLOC, 32'h0000_0000, 20'h00000);
        send_word(OP_ALLOC, 32'h0000_0000, 20'h00001);
        // free inside a slot, then the same slot again
        send_word(OP_FREE,  32'hFFFF_F7FF, 20'hFFFFF);
        send_word(OP_FREE,  32'hFFFF_F400, 20'h00000);
        send_word(OP_ALLOC, 32'h8000_0000, 20'hABCDE);
        // frame one emptied and returned, then freed once more
        send_word(OP_FREE,  32'h0000_1000, 20'h00000);
        send_word(OP_FREE,  32'h0000_1400, 20'h00000);
        send_word(OP_FREE,  32'h0000_1800, 20'h00000);
        // top frame emptied and returned
        send_word(OP_FREE,  32'hFFFF_F000, 20'h00000);
        send_word(OP_FREE,  32'hFFFF_F800, 20'h00000);
        send_word(OP_FREE,  32'hFFFF_FFFF, 20'h00000);
        send_word(OP_FREE,  32'hFFFF_F400, 20'h00000);
        drain_results();

        run_phase(26, 58, RANDOM_WORDS / 3);
        drain_results();
        run_phase(58, 26, RANDOM_WORDS / 3);
        drain_results();
        run_phase(0, 0, RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
